// File: hw/rtl/lcc_pkg.sv
package lcc_pkg;

    localparam int LOAD_SLOTS = 4;
    localparam int MAX_ROWS   = 16;
    localparam int SLOT_W     = 2;
    localparam int ROW_W      = 4;
    localparam int CNT_W      = 5;

    localparam logic [1:0] CMD_LOAD = 2'd1;
    localparam logic [1:0] CMD_CFG  = 2'd2;

    localparam logic [1:0] FSM_IDLE = 2'd0;
    localparam logic [1:0] FSM_WAIT = 2'd1;
    localparam logic [1:0] FSM_SEND = 2'd2;

    localparam logic [CNT_W-1:0] ROWS_MAX = CNT_W'(MAX_ROWS);

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_WAIT = 3'b010,
        PH_SEND = 3'b100
    } t_phase;

    typedef struct packed {
        logic [1:0]        cmd;
        logic              alloc_ready;
        logic [15:0]       alloc_id;
        logic              dma_ready;
        logic [CNT_W-1:0]  rows_to_read;
        logic [SLOT_W-1:0] cfg_slot;
        logic [31:0]       cfg_stride;
        logic [31:0]       cfg_scale;
        logic              cfg_shrink;
        logic [15:0]       cfg_block_stride;
        logic [7:0]        cfg_repeat;
        logic [SLOT_W-1:0] view_slot;
    } t_in;

    typedef struct packed {
        logic              head_ack;
        logic              alloc_request;
        logic              dma_valid;
        logic [15:0]       dma_id;
        logic [1:0]        fsm_now;
        logic [ROW_W-1:0]  row_now;
        logic              view_configured;
        logic [31:0]       view_stride;
        logic [31:0]       view_scale;
        logic              view_shrink;
        logic [15:0]       view_block_stride;
        logic [7:0]        view_repeat;
    } t_out;

    typedef struct packed {
        logic              head_ack;
        logic              alloc_request;
        logic              dma_valid;
        logic [15:0]       dma_id;
        logic [1:0]        fsm_now;
        logic [ROW_W-1:0]  row_now;
    } t_ctrl_out;

    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] slot;
        logic [31:0]       stride;
        logic [31:0]       scale;
        logic              shrink;
        logic [15:0]       blk_pitch;
        logic [7:0]        repeat_cnt;
    } t_slot_wr;

    typedef struct packed {
        logic              configured;
        logic [31:0]       stride;
        logic [31:0]       scale;
        logic              shrink;
        logic [15:0]       blk_pitch;
        logic [7:0]        repeat_cnt;
    } t_view;

endpackage

// File: hw/rtl/lcc_slots.sv
module lcc_slots (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  lcc_pkg::t_slot_wr            i_wr,
    input  logic                         i_repeat_en,
    input  logic [lcc_pkg::SLOT_W-1:0]   i_view_slot,
    output lcc_pkg::t_view               o_view
);
    import lcc_pkg::*;

    logic        r_valid        [LOAD_SLOTS];
    logic [31:0] r_stride       [LOAD_SLOTS];
    logic [31:0] r_scale        [LOAD_SLOTS];
    logic        r_shrink       [LOAD_SLOTS];
    logic [15:0] r_blk_pitch    [LOAD_SLOTS];
    logic [7:0]  r_repeat       [LOAD_SLOTS];
    logic [7:0]  n_repeat;

    // zero repeat means one, feature off forces one
    always_comb begin
        if (!i_repeat_en) begin
            n_repeat = 8'd1;
        end else if (i_wr.repeat_cnt == 8'd0) begin
            n_repeat = 8'd1;
        end else begin
            n_repeat = i_wr.repeat_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LOAD_SLOTS; i++) begin
                r_valid[i]        <= 1'b0;
                r_stride[i]       <= '0;
                r_scale[i]        <= '0;
                r_shrink[i]       <= 1'b0;
                r_blk_pitch[i]    <= '0;
                r_repeat[i]       <= 8'd1;
            end
        end else if (i_wr.we && (32'(i_wr.slot) < LOAD_SLOTS)) begin
            r_valid[i_wr.slot]        <= 1'b1;
            r_stride[i_wr.slot]       <= i_wr.stride;
            r_scale[i_wr.slot]        <= i_wr.scale;
            r_shrink[i_wr.slot]       <= i_wr.shrink;
            r_blk_pitch[i_wr.slot]    <= i_wr.blk_pitch;
            r_repeat[i_wr.slot]       <= n_repeat;
        end
    end

    always_comb begin
        o_view = '0;
        if (32'(i_view_slot) < LOAD_SLOTS) begin
            o_view.configured   = r_valid[i_view_slot];
            o_view.stride       = r_stride[i_view_slot];
            o_view.scale        = r_scale[i_view_slot];
            o_view.shrink       = r_shrink[i_view_slot];
            o_view.blk_pitch    = r_blk_pitch[i_view_slot];
            o_view.repeat_cnt   = i_repeat_en ? r_repeat[i_view_slot] : 8'd1;
        end
    end

endmodule

// File: hw/rtl/lcc_ctrl.sv
module lcc_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  lcc_pkg::t_in         i_item,
    output lcc_pkg::t_ctrl_out   o_res,
    output lcc_pkg::t_slot_wr    o_slot_wr
);
    import lcc_pkg::*;

    t_phase            r_phase, n_phase;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [15:0]       r_active_id, n_active_id;

    logic              idle;
    logic              allocating;
    logic              granted;
    logic              dma_valid;
    logic              fire;
    logic              ack;
    logic              last;
    logic [CNT_W-1:0]  count;
    logic [CNT_W-1:0]  row_inc;
    logic [1:0]        fsm_code;

    always_comb begin
        idle       = (r_phase == PH_IDLE);
        allocating = idle && (i_item.cmd == CMD_LOAD);
        granted    = allocating && i_item.alloc_ready;
        dma_valid  = granted || (r_phase == PH_WAIT) ||
                     ((r_phase == PH_SEND) && (r_row != '0));
        fire       = dma_valid && i_item.dma_ready;
        count      = (i_item.rows_to_read > ROWS_MAX) ? ROWS_MAX : i_item.rows_to_read;
        row_inc    = {1'b0, r_row} + CNT_W'(1);
        last       = (r_row == '0) ||
                     ((count != '0) && ({1'b0, r_row} == count - CNT_W'(1)) && fire);

        n_phase     = r_phase;
        n_active_id = r_active_id;
        ack         = 1'b0;

        if (idle && (i_item.cmd == CMD_CFG)) begin
            ack = 1'b1;
        end else if (granted) begin
            n_active_id = i_item.alloc_id;
            n_phase     = fire ? PH_SEND : PH_WAIT;
        end else if (r_phase == PH_WAIT) begin
            if (fire) begin
                n_phase = PH_SEND;
            end
        end else if (r_phase == PH_SEND) begin
            if (last) begin
                n_phase = PH_IDLE;
                ack     = 1'b1;
            end
        end

        if (fire) begin
            n_row = (row_inc >= count) ? '0 : row_inc[ROW_W-1:0];
        end else begin
            n_row = r_row;
        end

        case (r_phase)
            PH_IDLE: fsm_code = FSM_IDLE;
            PH_WAIT: fsm_code = FSM_WAIT;
            PH_SEND: fsm_code = FSM_SEND;
            default: fsm_code = FSM_IDLE;
        endcase
    end

    always_comb begin
        o_res.head_ack      = ack;
        o_res.alloc_request = allocating;
        o_res.dma_valid     = dma_valid;
        o_res.dma_id        = granted ? i_item.alloc_id : r_active_id;
        o_res.fsm_now       = fsm_code;
        o_res.row_now       = r_row;

        o_slot_wr.we           = i_en && idle && (i_item.cmd == CMD_CFG);
        o_slot_wr.slot         = i_item.cfg_slot;
        o_slot_wr.stride       = i_item.cfg_stride;
        o_slot_wr.scale        = i_item.cfg_scale;
        o_slot_wr.shrink       = i_item.cfg_shrink;
        o_slot_wr.blk_pitch    = i_item.cfg_block_stride;
        o_slot_wr.repeat_cnt   = i_item.cfg_repeat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_row       <= '0;
            r_active_id <= '0;
        end else if (i_en) begin
            r_phase     <= n_phase;
            r_row       <= n_row;
            r_active_id <= n_active_id;
        end
    end

endmodule

// File: hw/rtl/load_command_controller_core.sv
// channel   valid         ready         payload
// input     i_in_valid    o_in_ready    i_item   (lcc_pkg::t_in)
// result    o_out_valid   i_out_ready   o_result (lcc_pkg::t_out)
// config    i_cfg_we      -             i_cfg_wdata (pixel repeat enable)
//
// one item per cycle unless the result stalls; an item passes from the input
// register through one combinational pass into the result register
// synchronous active-low reset: control idle, slots cleared, repeat enable on
// a stalled result holds the item in the input register and ready follows
// i_out_ready, so a full pipe keeps streaming while the result is taken
module load_command_controller_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  lcc_pkg::t_in      i_item,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output lcc_pkg::t_out     o_result,
    input  logic              i_cfg_we,
    input  logic              i_cfg_wdata
);
    import lcc_pkg::*;

    logic       r_in_valid;
    t_in        r_in;
    logic       r_out_valid;
    t_out       r_out;
    logic       r_repeat_en;
    logic       adv;
    t_ctrl_out  ctrl_res;
    t_slot_wr   slot_wr;
    t_view      view;
    t_out       n_out;

    assign adv        = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_repeat_en <= 1'b1;
        end else if (i_cfg_we) begin
            r_repeat_en <= i_cfg_wdata;
        end
    end

    lcc_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (adv),
        .i_item    (r_in),
        .o_res     (ctrl_res),
        .o_slot_wr (slot_wr)
    );

    lcc_slots u_slots (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr        (slot_wr),
        .i_repeat_en (r_repeat_en),
        .i_view_slot (r_in.view_slot),
        .o_view      (view)
    );

    always_comb begin
        n_out.head_ack          = ctrl_res.head_ack;
        n_out.alloc_request     = ctrl_res.alloc_request;
        n_out.dma_valid         = ctrl_res.dma_valid;
        n_out.dma_id            = ctrl_res.dma_id;
        n_out.fsm_now           = ctrl_res.fsm_now;
        n_out.row_now           = ctrl_res.row_now;
        n_out.view_configured   = view.configured;
        n_out.view_stride       = view.stride;
        n_out.view_scale        = view.scale;
        n_out.view_shrink       = view.shrink;
        n_out.view_block_stride = view.blk_pitch;
        n_out.view_repeat       = view.repeat_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

    a_alloc_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_result.alloc_request) |-> (o_result.fsm_now == FSM_IDLE))
        else $error("allocation request outside idle");

    a_idle_dma_needs_alloc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_result.dma_valid && (o_result.fsm_now == FSM_IDLE))
        |-> o_result.alloc_request)
        else $error("dma request from idle without allocation");

    a_send_row_zero_acks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_result.fsm_now == FSM_SEND) && (o_result.row_now == '0))
        |-> (o_result.head_ack && !o_result.dma_valid))
        else $error("send phase at row zero did not finish");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && o_in_ready))
        else $error("pipeline not empty after reset");

endmodule
